[design/ifr_pkg.sv]
// ----------------------------------------------------------------------------
// ifr_pkg
// Shared types, constants and a helper function of the information frame
// receiver.
// ----------------------------------------------------------------------------
package ifr_pkg;

  localparam int MAX_FRAME_BYTES = 1536;
  localparam int CNT_W           = 11;
  localparam int QDEPTH          = 4;
  localparam int QAW             = $clog2(QDEPTH);
  localparam int QCW             = $clog2(QDEPTH + 1);

  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] ESC_FLAG     = 8'h5E;
  localparam logic [7:0] ESC_ESC      = 8'h5D;
  localparam logic [7:0] CTRL_SEQ0    = 8'h00;
  localparam logic [7:0] CTRL_SEQ1    = 8'h40;
  localparam logic [7:0] CTRL_SET     = 8'h03;
  localparam logic [7:0] CTRL_REJ     = 8'h01;
  localparam logic [7:0] CTRL_UA      = 8'h07;
  localparam logic [7:0] ADDR_RESET   = 8'h03;
  localparam logic [7:0] CHECK_RESET  = 8'hFF;

  localparam logic [2:0] ST_ACCEPT = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_REJ    = 3'd2;
  localparam logic [2:0] ST_SET    = 3'd3;
  localparam logic [2:0] ST_DROP   = 3'd4;

  typedef struct packed {
    logic [7:0] value;
    logic       is_flag;
  } line_item_t;

  typedef struct packed {
    logic       valid;
    line_item_t item;
  } queue_head_t;

  function automatic logic [7:0] reply_ctrl(input logic [2:0] status,
                                            input logic [7:0] hdr_ctrl);
    logic [7:0] ctrl;
    ctrl = 8'h00;
    unique case (status)
      ST_ACCEPT, ST_DUP: ctrl = (hdr_ctrl == CTRL_SEQ0) ? CTRL_SEQ1 : CTRL_SEQ0;
      ST_REJ:            ctrl = CTRL_REJ;
      ST_SET:            ctrl = CTRL_UA;
      default:           ctrl = 8'h00;
    endcase
    return ctrl;
  endfunction

endpackage

[design/ifr_front.sv]
// ----------------------------------------------------------------------------
// ifr_front
// Accepts line bytes, marks flag bytes, and queues them for the frame engine.
// ----------------------------------------------------------------------------
module ifr_front import ifr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        line_valid,
  output logic        line_stall,
  input  logic [7:0]  line_byte,
  output queue_head_t head,
  input  logic        pop
);

  line_item_t       entries [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;
  logic             push;
  logic             do_pop;
  line_item_t       incoming;

  assign line_stall = (count == QCW'(QDEPTH));
  assign push       = line_valid && !line_stall;
  assign do_pop     = pop && (count != '0);

  assign incoming.value   = line_byte;
  assign incoming.is_flag = (line_byte == FLAG_BYTE);

  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCW'(push) - QCW'(do_pop);
    end
  end

endmodule

[design/ifr_back.sv]
// ----------------------------------------------------------------------------
// ifr_back
// Frame engine: header checks, destuffing, BCC2 check, end-of-frame report,
// and the output register.
// ----------------------------------------------------------------------------
module ifr_back import ifr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        config_valid,
  output logic        config_ready,
  input  logic [7:0]  config_data,
  input  queue_head_t head,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        is_frame_end,
  output logic [7:0]  data_byte,
  output logic [2:0]  frame_status,
  output logic        reply_valid,
  output logic [7:0]  reply_control
);

  logic [7:0]       station_address;
  logic [CNT_W-1:0] raw_count, raw_count_next;
  logic             first_is_flag, first_is_flag_next;
  logic [7:0]       header_addr, header_addr_next;
  logic [7:0]       header_ctrl, header_ctrl_next;
  logic [7:0]       held_byte, held_byte_next;
  logic             held_valid, held_valid_next;
  logic             escape_pending, escape_pending_next;
  logic             frame_error, frame_error_next;
  logic [7:0]       check_accum, check_accum_next;
  logic [7:0]       last_check_byte, last_check_byte_next;

  logic             emit;
  logic             emit_end;
  logic [7:0]       emit_data;
  logic [2:0]       emit_status;
  logic [CNT_W-1:0] count_inc;
  logic             hdr_match;
  logic             ctrl_info;
  logic             ctrl_set;
  logic             overflow;
  logic             live;
  logic [7:0]       b;

  assign config_ready = 1'b1;
  assign pop          = head.valid && (!result_valid || !result_stall);

  assign b         = head.item.value;
  assign count_inc = raw_count + 1'b1;
  assign overflow  = (count_inc >= CNT_W'(MAX_FRAME_BYTES));
  assign hdr_match = first_is_flag && (header_addr == station_address);
  assign ctrl_info = (header_ctrl == CTRL_SEQ0) || (header_ctrl == CTRL_SEQ1);
  assign ctrl_set  = (header_ctrl == CTRL_SET);
  assign live      = hdr_match && ctrl_info && !frame_error && held_valid;

  always_comb begin
    raw_count_next       = raw_count;
    first_is_flag_next   = first_is_flag;
    header_addr_next     = header_addr;
    header_ctrl_next     = header_ctrl;
    held_byte_next       = held_byte;
    held_valid_next      = held_valid;
    escape_pending_next  = escape_pending;
    frame_error_next     = frame_error;
    check_accum_next     = check_accum;
    last_check_byte_next = last_check_byte;
    emit        = 1'b0;
    emit_end    = 1'b0;
    emit_data   = 8'h00;
    emit_status = ST_ACCEPT;

    if (raw_count == '0) begin
      first_is_flag_next = head.item.is_flag;
      check_accum_next   = 8'h00;
      raw_count_next     = CNT_W'(1);
    end else if (!first_is_flag) begin
      raw_count_next = count_inc;
      if (head.item.is_flag) begin
        emit = 1'b1;
        emit_end = 1'b1;
        emit_status = ST_DROP;
      end else if (overflow) begin
        emit = 1'b1;
        emit_end = 1'b1;
        emit_status = ST_REJ;
      end
    end else if (head.item.is_flag) begin
      emit = 1'b1;
      emit_end = 1'b1;
      priority if (hdr_match && ctrl_set && !frame_error &&
                   raw_count >= CNT_W'(4)) begin
        emit_status = ST_SET;
      end else if (!(hdr_match && ctrl_info && raw_count >= CNT_W'(4)) ||
                   frame_error || !held_valid || escape_pending) begin
        emit_status = ST_REJ;
      end else if (held_byte != check_accum) begin
        emit_status = ST_REJ;
      end else if (held_byte == last_check_byte) begin
        emit_status = ST_DUP;
      end else begin
        emit_status = ST_ACCEPT;
        last_check_byte_next = held_byte;
      end
    end else begin
      raw_count_next = count_inc;
      if (overflow) begin
        emit = 1'b1;
        emit_end = 1'b1;
        emit_status = (hdr_match && ctrl_set && !frame_error) ? ST_SET : ST_REJ;
      end else if (raw_count == CNT_W'(1)) begin
        header_addr_next = b;
      end else if (raw_count == CNT_W'(2)) begin
        header_ctrl_next = b;
      end else if (raw_count == CNT_W'(3)) begin
        if ((header_addr ^ header_ctrl) != b) begin
          frame_error_next = 1'b1;
        end
      end else begin
        held_byte_next  = b;
        held_valid_next = 1'b1;
        if (live) begin
          if (escape_pending) begin
            escape_pending_next = 1'b0;
            priority if (held_byte == ESC_FLAG) begin
              emit = 1'b1;
              emit_data = FLAG_BYTE;
            end else if (held_byte == ESC_ESC) begin
              emit = 1'b1;
              emit_data = ESC_BYTE;
            end else begin
              frame_error_next = 1'b1;
            end
          end else if (held_byte == ESC_BYTE) begin
            escape_pending_next = 1'b1;
          end else begin
            emit = 1'b1;
            emit_data = held_byte;
          end
          if (emit) begin
            check_accum_next = check_accum ^ emit_data;
          end
        end
      end
    end

    if (emit_end) begin
      raw_count_next      = '0;
      first_is_flag_next  = 1'b0;
      header_addr_next    = 8'h00;
      header_ctrl_next    = 8'h00;
      held_byte_next      = 8'h00;
      held_valid_next     = 1'b0;
      escape_pending_next = 1'b0;
      frame_error_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= ADDR_RESET;
      raw_count       <= '0;
      first_is_flag   <= 1'b0;
      header_addr     <= 8'h00;
      header_ctrl     <= 8'h00;
      held_byte       <= 8'h00;
      held_valid      <= 1'b0;
      escape_pending  <= 1'b0;
      frame_error     <= 1'b0;
      check_accum     <= 8'h00;
      last_check_byte <= CHECK_RESET;
      result_valid    <= 1'b0;
    end else begin
      if (config_valid && config_ready) begin
        station_address <= config_data;
      end
      if (pop) begin
        raw_count       <= raw_count_next;
        first_is_flag   <= first_is_flag_next;
        header_addr     <= header_addr_next;
        header_ctrl     <= header_ctrl_next;
        held_byte       <= held_byte_next;
        held_valid      <= held_valid_next;
        escape_pending  <= escape_pending_next;
        frame_error     <= frame_error_next;
        check_accum     <= check_accum_next;
        last_check_byte <= last_check_byte_next;
        result_valid    <= emit;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      is_frame_end  <= emit_end;
      data_byte     <= emit_end ? 8'h00 : emit_data;
      frame_status  <= emit_end ? emit_status : ST_ACCEPT;
      reply_valid   <= emit_end && (emit_status != ST_DROP);
      reply_control <= emit_end ? reply_ctrl(emit_status, header_ctrl) : 8'h00;
    end
  end

endmodule

[design/info_frame_receiver_core.sv]
// A line byte is written into the front queue; the frame engine takes it from the
// queue head and its result is registered in the output register.
// A data byte comes out with the next raw byte of the frame, since the last byte is
// held back as BCC2.
// Throughput: one line byte per cycle while no stalled result holds the frame engine.
// Reset (rst, synchronous): empties the queue and output, address returns to 3.
// ----------------------------------------------------------------------------
// info_frame_receiver_core
// Top level: byte-stuffed information frame receiver with stop-and-wait reply.
// ----------------------------------------------------------------------------
module info_frame_receiver_core import ifr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       config_valid,
  output logic       config_ready,
  input  logic [7:0] config_data,
  input  logic       line_valid,
  output logic       line_stall,
  input  logic [7:0] line_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       is_frame_end,
  output logic [7:0] data_byte,
  output logic [2:0] frame_status,
  output logic       reply_valid,
  output logic [7:0] reply_control
);

  queue_head_t head;
  logic        pop;

  ifr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .line_valid (line_valid),
    .line_stall (line_stall),
    .line_byte  (line_byte),
    .head       (head),
    .pop        (pop)
  );

  ifr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .config_valid  (config_valid),
    .config_ready  (config_ready),
    .config_data   (config_data),
    .head          (head),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .is_frame_end  (is_frame_end),
    .data_byte     (data_byte),
    .frame_status  (frame_status),
    .reply_valid   (reply_valid),
    .reply_control (reply_control)
  );

endmodule

[design/ifr_checker.sv]
// ----------------------------------------------------------------------------
// ifr_checker
// Port-level checks of the information frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module ifr_checker import ifr_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       config_ready,
  input logic       result_valid,
  input logic       result_stall,
  input logic       is_frame_end,
  input logic [7:0] data_byte,
  input logic [2:0] frame_status,
  input logic       reply_valid,
  input logic [7:0] reply_control
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(data_byte) &&
      $stable(frame_status) && $stable(is_frame_end) && $stable(reply_control))
    else $error("Stalled result changed.");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_frame_end |->
      frame_status == ST_ACCEPT && !reply_valid && reply_control == 8'h00)
    else $error("Data result carries report fields.");

  a_drop_reply: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_frame_end |->
      (reply_valid == (frame_status != ST_DROP)) && data_byte == 8'h00)
    else $error("Report reply flag does not match status.");

  a_reply_code: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_frame_end && frame_status == ST_REJ |->
      reply_control == CTRL_REJ)
    else $error("Rejected frame without REJ reply.");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) config_ready)
    else $error("Configuration port not ready.");

endmodule

bind info_frame_receiver_core ifr_checker u_ifr_checker (
  .clk           (clk),
  .rst           (rst),
  .config_ready  (config_ready),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .is_frame_end  (is_frame_end),
  .data_byte     (data_byte),
  .frame_status  (frame_status),
  .reply_valid   (reply_valid),
  .reply_control (reply_control)
);
